/* hdl/rqs_pkg.sv */
// ----------------------------------------------------------------------------
// Run queue scheduler package
// Item types and operation codes shared by the run queue scheduler.
// ----------------------------------------------------------------------------
package rqs_pkg;

  // Operation codes carried in the op field of an input item.
  localparam logic [2:0] OP_ADD_LEAST    = 3'd0;
  localparam logic [2:0] OP_ADD_CPU      = 3'd1;
  localparam logic [2:0] OP_REMOVE       = 3'd2;
  localparam logic [2:0] OP_SCHEDULE     = 3'd3;
  localparam logic [2:0] OP_MARK_STOPPED = 3'd4;
  localparam logic [2:0] OP_POST_SIGNAL  = 3'd5;
  // The two remaining codes are unused and leave the state alone.
  localparam logic [2:0] OP_RSVD_6       = 3'd6;
  localparam logic [2:0] OP_RSVD_7       = 3'd7;

  // Signal word layout.
  localparam int SIGNAL_BITS  = 32;
  localparam int KILL_SIG_BIT = 8;

  localparam logic [3:0] CPU_COUNT_RESET = 4'd1;

  typedef struct packed {
    logic [2:0] op;
    logic [2:0] cpu;
    logic [5:0] thread_slot;
    logic       kernel_thread;
    logic [5:0] current_slot;
    logic       current_is_idle;
    logic [5:0] signal_number;
    logic       stopped_value;
  } in_item_t;

  typedef struct packed {
    logic              status;
    logic [2:0]        chosen_cpu;
    logic signed [31:0] assigned_pid;
    logic [5:0]        next_slot;
    logic              next_is_idle;
    logic [5:0]        deliver_signal;
  } out_item_t;

endpackage

/* hdl/per_cpu_run_queue_scheduler.sv */
// ----------------------------------------------------------------------------
// Per-CPU run queue scheduler
// Thread slots linked into one doubly linked run queue per CPU, with add,
// remove, schedule, stop marks and pending signals.
// ----------------------------------------------------------------------------
//
//   Channel   Handshake               Payload
//   -------   ---------------------   ---------------------------
//   config    cfg_write               cfg_data (cpu_count)
//   input     in_valid / in_stall     in_item  (rqs_pkg::in_item_t)
//   output    out_valid / out_stall   out_item (rqs_pkg::out_item_t)
//
// One item is worked on at a time. Mark stopped goes from decode straight to
// DONE; remove passes through RM, post signal through POST, add to a given CPU
// through ADD1 and, on a nonempty queue, ADD2 (the next-link memory has a single
// write port), and schedule through PICK and, unless idle, SIG. Add to the
// least-loaded CPU first runs the one-CPU-per-cycle size scan over the clamped CPU count.
// Reset clears queues, marks and pending signals at once; no clearing pass.
// A stalled output holds the finished item in the DONE state until taken.

module per_cpu_run_queue_scheduler #(
  parameter int MAX_CPUS    = 8,
  parameter int MAX_THREADS = 64
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_write,
  input  logic [3:0]          cfg_data,
  input  logic                in_valid,
  output logic                in_stall,
  input  rqs_pkg::in_item_t   in_item,
  output logic                out_valid,
  input  logic                out_stall,
  output rqs_pkg::out_item_t  out_item
);

  localparam int AW  = $clog2(MAX_THREADS);
  localparam int SW  = $clog2(MAX_THREADS + 1);
  localparam int CW  = (MAX_CPUS > 1) ? $clog2(MAX_CPUS) : 1;
  localparam int CNW = $clog2(MAX_CPUS + 1);
  localparam logic [SW-1:0] NIL = SW'(MAX_THREADS);

  typedef enum logic [3:0] {
    S_IDLE, S_DECODE, S_SCAN, S_ADD1, S_ADD2, S_RM,
    S_PICK, S_SIG, S_POST, S_DONE
  } state_t;

  state_t              state;
  rqs_pkg::in_item_t   item;
  rqs_pkg::out_item_t  res;
  logic [3:0]          cpu_count;
  logic [SW-1:0]       head [MAX_CPUS];
  logic [SW-1:0]       tail [MAX_CPUS];
  logic [SW-1:0]       qsize [MAX_CPUS];
  logic [MAX_THREADS-1:0] queued;
  logic [MAX_THREADS-1:0] stopped;
  logic [MAX_THREADS-1:0] pend_vld;
  logic [31:0]         user_pid;
  logic [31:0]         kern_pid;
  logic [CW-1:0]       tgt_cpu;
  logic [CNW-1:0]      scan_idx;
  logic [SW-1:0]       scan_min;
  logic [SW-1:0]       sch_to;
  logic [SW-1:0]       prev_tail;
  logic                use_link;

  // Per-slot memories.
  logic [SW-1:0] nxt_mem  [MAX_THREADS];
  logic [SW-1:0] prv_mem  [MAX_THREADS];
  logic [CW-1:0] cpu_mem  [MAX_THREADS];
  logic [31:0]   pend_mem [MAX_THREADS];
  logic [SW-1:0] nxt_rd, prv_rd;
  logic [CW-1:0] cpu_rd;
  logic [31:0]   pend_rd;

  logic [AW-1:0] nxt_ra, pend_ra;
  logic          nxt_we, prv_we, cpu_we, pend_we;
  logic [AW-1:0] nxt_wa, prv_wa, cpu_wa, pend_wa;
  logic [SW-1:0] nxt_wd, prv_wd;
  logic [CW-1:0] cpu_wd;
  logic [31:0]   pend_wd;

  // Decoded item fields.
  logic          slot_ok, cur_ok, sig_ok;
  logic [AW-1:0] s_a, cur_a;
  logic [SW-1:0] s_w;
  logic [6:0]    cpu_v;
  logic [CW-1:0] cpu_c;
  logic [31:0]   n_int;
  logic [CNW-1:0] n_eff;
  logic [SW-1:0] tail_t;
  logic [SW-1:0] pick_to;
  logic          pick_idle;
  logic [31:0]   sch_q, low_bit, post_q, sig_bit;
  logic [4:0]    low_idx;

  always_comb begin
    slot_ok = (32'(item.thread_slot) < 32'(MAX_THREADS));
    cur_ok  = (32'(item.current_slot) < 32'(MAX_THREADS));
    s_a     = AW'(item.thread_slot);
    s_w     = SW'(item.thread_slot);
    cur_a   = AW'(item.current_slot);
    sig_ok  = (item.signal_number >= 6'd1) &&
              (32'(item.signal_number) <= 32'(rqs_pkg::SIGNAL_BITS));
    sig_bit = 32'(1) << (item.signal_number - 6'd1);

    // CPU index modulo the queue count, by repeated subtraction.
    cpu_v = 7'(item.cpu);
    for (int i = 0; i < 8; i++) begin
      if (32'(cpu_v) >= 32'(MAX_CPUS)) cpu_v = cpu_v - 7'(MAX_CPUS);
    end
    cpu_c = CW'(cpu_v);

    // Number of CPUs in use, clamped to the supported range.
    if (cpu_count == 4'd0) n_int = 32'd1;
    else if (32'(cpu_count) > 32'(MAX_CPUS)) n_int = 32'(MAX_CPUS);
    else n_int = 32'(cpu_count);
    n_eff = CNW'(n_int);

    tail_t = tail[tgt_cpu];

    // Schedule pick: successor of the current thread, else the queue head.
    pick_to   = (use_link && nxt_rd != NIL) ? nxt_rd : head[cpu_c];
    pick_idle = (pick_to == NIL) || stopped[AW'(pick_to)];

    // Lowest pending signal.
    sch_q   = pend_vld[AW'(sch_to)] ? pend_rd : 32'd0;
    low_bit = sch_q & (~sch_q + 32'd1);
    low_idx = '0;
    for (int i = 0; i < rqs_pkg::SIGNAL_BITS; i++) begin
      if (low_bit[i]) low_idx = low_idx | 5'(i);
    end
    post_q = pend_vld[s_a] ? pend_rd : 32'd0;
  end

  // Memory read addresses.
  always_comb begin
    nxt_ra  = (item.op == rqs_pkg::OP_SCHEDULE) ? cur_a : s_a;
    pend_ra = (state == S_PICK) ? AW'(pick_to) : s_a;
  end

  // Memory write ports.
  always_comb begin
    nxt_we = 1'b0; nxt_wa = s_a; nxt_wd = NIL;
    prv_we = 1'b0; prv_wa = s_a; prv_wd = tail_t;
    cpu_we = 1'b0; cpu_wa = s_a; cpu_wd = tgt_cpu;
    pend_we = 1'b0; pend_wa = s_a; pend_wd = post_q | sig_bit;
    unique case (state)
      S_ADD1: begin
        nxt_we = 1'b1;
        prv_we = 1'b1;
        cpu_we = 1'b1;
      end
      S_ADD2: begin
        nxt_we = 1'b1;
        nxt_wa = AW'(prev_tail);
        nxt_wd = s_w;
      end
      S_RM: begin
        nxt_we = (prv_rd != NIL);
        nxt_wa = AW'(prv_rd);
        nxt_wd = nxt_rd;
        prv_we = (nxt_rd != NIL);
        prv_wa = AW'(nxt_rd);
        prv_wd = prv_rd;
      end
      S_SIG: begin
        pend_we = !sch_q[rqs_pkg::KILL_SIG_BIT] && (sch_q != 32'd0);
        pend_wa = AW'(sch_to);
        pend_wd = sch_q & ~low_bit;
      end
      S_POST: begin
        pend_we = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (nxt_we) nxt_mem[nxt_wa] <= nxt_wd;
    nxt_rd <= nxt_mem[nxt_ra];
  end

  always_ff @(posedge clk) begin
    if (prv_we) prv_mem[prv_wa] <= prv_wd;
    prv_rd <= prv_mem[s_a];
  end

  always_ff @(posedge clk) begin
    if (cpu_we) cpu_mem[cpu_wa] <= cpu_wd;
    cpu_rd <= cpu_mem[s_a];
  end

  always_ff @(posedge clk) begin
    if (pend_we) pend_mem[pend_wa] <= pend_wd;
    pend_rd <= pend_mem[pend_ra];
  end

  assign in_stall = (state != S_IDLE);

  // Sequencer, queue registers and result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cpu_count <= rqs_pkg::CPU_COUNT_RESET;
      for (int i = 0; i < MAX_CPUS; i++) begin
        head[i]  <= NIL;
        tail[i]  <= NIL;
        qsize[i] <= '0;
      end
      queued    <= '0;
      stopped   <= '0;
      pend_vld  <= '0;
      user_pid  <= 32'd1;
      kern_pid  <= 32'd1;
      use_link  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_write) cpu_count <= cfg_data;

      // The output register is loaded from DONE when free and cleared when taken.
      if ((state == S_DONE) && (!out_valid || !out_stall)) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            item  <= in_item;
            state <= S_DECODE;
          end
        end
        S_DECODE: begin
          res   <= '0;
          state <= S_DONE;
          unique case (item.op)
            rqs_pkg::OP_ADD_LEAST: begin
              if (slot_ok && !queued[s_a]) begin
                scan_idx <= CNW'(1);
                tgt_cpu  <= '0;
                scan_min <= qsize[0];
                state    <= S_SCAN;
              end
            end
            rqs_pkg::OP_ADD_CPU: begin
              if (slot_ok && !queued[s_a]) begin
                tgt_cpu <= cpu_c;
                state   <= S_ADD1;
              end
            end
            rqs_pkg::OP_REMOVE: begin
              if (slot_ok && queued[s_a]) state <= S_RM;
            end
            rqs_pkg::OP_SCHEDULE: begin
              use_link <= !item.current_is_idle && cur_ok && queued[cur_a];
              state    <= S_PICK;
            end
            rqs_pkg::OP_MARK_STOPPED: begin
              if (slot_ok) stopped[s_a] <= item.stopped_value;
            end
            rqs_pkg::OP_POST_SIGNAL: begin
              if (slot_ok && sig_ok) state <= S_POST;
            end
            default: begin
            end
          endcase
        end
        // One CPU size compared per cycle; the first minimum wins.
        S_SCAN: begin
          if (scan_idx < n_eff) begin
            if (qsize[scan_idx[CW-1:0]] < scan_min) begin
              scan_min <= qsize[scan_idx[CW-1:0]];
              tgt_cpu  <= scan_idx[CW-1:0];
            end
            scan_idx <= scan_idx + CNW'(1);
          end else begin
            state <= S_ADD1;
          end
        end
        // Append at the tail and hand out a pid.
        S_ADD1: begin
          prev_tail <= tail_t;
          if (tail_t == NIL) head[tgt_cpu] <= s_w;
          tail[tgt_cpu]  <= s_w;
          qsize[tgt_cpu] <= qsize[tgt_cpu] + SW'(1);
          queued[s_a]    <= 1'b1;
          res.chosen_cpu <= 3'(tgt_cpu);
          if (item.kernel_thread) begin
            res.assigned_pid <= 32'd0 - kern_pid;
            kern_pid         <= kern_pid + 32'd1;
          end else begin
            res.assigned_pid <= user_pid;
            user_pid         <= user_pid + 32'd1;
          end
          state <= (tail_t != NIL) ? S_ADD2 : S_DONE;
        end
        S_ADD2: begin
          state <= S_DONE;
        end
        // Unlink using the slot's recorded neighbors and CPU.
        S_RM: begin
          if (prv_rd == NIL) head[cpu_rd] <= nxt_rd;
          if (nxt_rd == NIL) tail[cpu_rd] <= prv_rd;
          qsize[cpu_rd] <= qsize[cpu_rd] - SW'(1);
          queued[s_a]   <= 1'b0;
          state         <= S_DONE;
        end
        S_PICK: begin
          sch_to <= pick_to;
          if (pick_idle) begin
            res.next_is_idle <= 1'b1;
            state            <= S_DONE;
          end else begin
            res.next_slot <= 6'(pick_to);
            state         <= S_SIG;
          end
        end
        // A pending kill is reported; otherwise the lowest signal is taken.
        S_SIG: begin
          if (sch_q[rqs_pkg::KILL_SIG_BIT]) begin
            res.status <= 1'b1;
          end else if (sch_q != 32'd0) begin
            res.deliver_signal <= 6'(low_idx) + 6'd1;
          end
          state <= S_DONE;
        end
        S_POST: begin
          pend_vld[s_a] <= 1'b1;
          state         <= S_DONE;
        end
        S_DONE: begin
          if (!out_valid || !out_stall) begin
            out_item <= res;
            state    <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // An accepted item blocks the input until its result is issued.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("input accepted while an item was in flight");

  // A finished item with a free output register is issued next cycle.
  a_done_issues: assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE) && (!out_valid || !out_stall) |=> out_valid && !in_stall)
    else $error("finished item not issued");

  // An empty queue 0 has no head, a nonempty one has one.
  a_empty_head: assert property (@(posedge clk) disable iff (rst)
    (qsize[0] == '0) == (head[0] == NIL))
    else $error("queue size and head disagree");

endmodule

/* bench/per_cpu_run_queue_scheduler_test.sv */
// ----------------------------------------------------------------------------
// Run queue scheduler testbench
// Drives add, remove, schedule, stop and signal items into the per-CPU run
// queue scheduler, predicts each result from a behavioral copy of the queues,
// and compares every result item field by field in order.
// ----------------------------------------------------------------------------
module per_cpu_run_queue_scheduler_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NCPU = 8;
  localparam int NSLOT = 64;
  localparam logic [6:0] NIL = 7'd64;
  localparam int IDLE_LIMIT = 20000;
  localparam int HOLD_PHASE = 1;
  localparam int HOLD_CYCLES = 300;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_write = 1'b0;
  logic [3:0] cfg_data = 4'd0;
  logic in_valid = 1'b0;
  logic in_stall;
  rqs_pkg::in_item_t in_item = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  rqs_pkg::out_item_t out_item;

  per_cpu_run_queue_scheduler dut (
    .clk(clk), .rst(rst), .cfg_write(cfg_write), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall), .in_item(in_item),
    .out_valid(out_valid), .out_stall(out_stall), .out_item(out_item)
  );

  always #1 clk = ~clk;

  // Shadow copy of the scheduler state.
  logic [3:0] cpus_cfg;
  logic [6:0] head_q[NCPU], tail_q[NCPU];
  int unsigned size_q[NCPU];
  logic [6:0] nxt[NSLOT], prv[NSLOT];
  logic [2:0] home_cpu[NSLOT];
  logic stop_mark[NSLOT], on_queue[NSLOT];
  logic [31:0] sig_pend[NSLOT];
  logic [31:0] user_pid, kern_pid;

  rqs_pkg::in_item_t pending_items[$];
  rqs_pkg::out_item_t expected_results[$];
  int errors = 0;
  int idle_pct = 0, stall_pct = 0;
  int phase = 0;
  int hold_off = 0;
  logic hold_armed = 1'b0;

  task automatic report(string what);
    errors++;
    $display("mismatch: %s", what);
  endtask

  task automatic clear_shadow();
    cpus_cfg = rqs_pkg::CPU_COUNT_RESET;
    for (int i = 0; i < NCPU; i++) begin
      head_q[i] = NIL; tail_q[i] = NIL; size_q[i] = 0;
    end
    for (int i = 0; i < NSLOT; i++) begin
      nxt[i] = NIL; prv[i] = NIL; home_cpu[i] = 3'd0;
      stop_mark[i] = 1'b0; on_queue[i] = 1'b0; sig_pend[i] = 32'd0;
    end
    user_pid = 32'd1; kern_pid = 32'd1;
  endtask

  function automatic int lightest_cpu();
    int n, best;
    int unsigned lo;
    n = (cpus_cfg == 4'd0) ? 1 : (int'(cpus_cfg) > NCPU ? NCPU : int'(cpus_cfg));
    best = 0;
    lo = 32'hFFFF_FFFF;
    for (int i = 0; i < n; i++)
      if (size_q[i] < lo) begin
        lo = size_q[i]; best = i;
      end
    return best;
  endfunction

  // Applies one item to the shadow state and returns its expected result.
  function automatic rqs_pkg::out_item_t predict_step(rqs_pkg::in_item_t it);
    rqs_pkg::out_item_t r;
    int c, s, to;
    logic [6:0] p, n;
    logic [31:0] q;
    r = '0;
    s = int'(it.thread_slot);
    case (it.op)
      rqs_pkg::OP_ADD_LEAST, rqs_pkg::OP_ADD_CPU: begin
        if (!on_queue[s]) begin
          c = (it.op == rqs_pkg::OP_ADD_LEAST) ? lightest_cpu() : int'(it.cpu);
          nxt[s] = NIL;
          prv[s] = tail_q[c];
          if (tail_q[c] != NIL) nxt[tail_q[c]] = 7'(s);
          else head_q[c] = 7'(s);
          tail_q[c] = 7'(s);
          size_q[c]++;
          home_cpu[s] = 3'(c);
          on_queue[s] = 1'b1;
          r.chosen_cpu = 3'(c);
          if (it.kernel_thread) begin
            r.assigned_pid = 32'd0 - kern_pid; kern_pid++;
          end else begin
            r.assigned_pid = user_pid; user_pid++;
          end
        end
      end
      rqs_pkg::OP_REMOVE: begin
        if (on_queue[s]) begin
          c = int'(home_cpu[s]); p = prv[s]; n = nxt[s];
          if (p != NIL) nxt[p] = n; else head_q[c] = n;
          if (n != NIL) prv[n] = p; else tail_q[c] = p;
          size_q[c]--;
          nxt[s] = NIL; prv[s] = NIL; on_queue[s] = 1'b0;
        end
      end
      rqs_pkg::OP_SCHEDULE: begin
        to = int'(NIL);
        if (!it.current_is_idle && on_queue[it.current_slot])
          to = int'(nxt[it.current_slot]);
        if (to == int'(NIL)) to = int'(head_q[it.cpu]);
        if (to == int'(NIL) || stop_mark[to]) r.next_is_idle = 1'b1;
        else begin
          r.next_slot = 6'(to);
          q = sig_pend[to];
          if (q[rqs_pkg::KILL_SIG_BIT]) r.status = 1'b1;
          else
            for (int i = 0; i < rqs_pkg::SIGNAL_BITS; i++)
              if (q[i]) begin
                sig_pend[to][i] = 1'b0;
                r.deliver_signal = 6'(i + 1);
                break;
              end
        end
      end
      rqs_pkg::OP_MARK_STOPPED: stop_mark[s] = it.stopped_value;
      rqs_pkg::OP_POST_SIGNAL:
        if (it.signal_number >= 6'd1 && int'(it.signal_number) <= rqs_pkg::SIGNAL_BITS)
          sig_pend[s][it.signal_number - 6'd1] = 1'b1;
      default: ;
    endcase
    return r;
  endfunction

  function automatic rqs_pkg::in_item_t make_item(logic [2:0] op, int cpu, int slot);
    rqs_pkg::in_item_t it;
    it = '0;
    it.op = op;
    it.cpu = 3'(cpu);
    it.thread_slot = 6'(slot);
    it.kernel_thread = 1'($urandom_range(0, 1));
    it.current_slot = 6'($urandom_range(0, 63));
    it.current_is_idle = ($urandom_range(0, 3) == 0);
    it.signal_number = 6'($urandom_range(0, 63));
    it.stopped_value = ($urandom_range(0, 3) == 0);
    return it;
  endfunction

  // Random item biased toward a small working set of slots.
  function automatic rqs_pkg::in_item_t random_item();
    rqs_pkg::in_item_t it;
    int pick, slot;
    pick = int'($urandom_range(0, 99));
    slot = ($urandom_range(0, 4) == 0) ? int'($urandom_range(0, 63))
                                       : int'($urandom_range(0, 15));
    if (pick < 18) it = make_item(rqs_pkg::OP_ADD_LEAST, 0, slot);
    else if (pick < 33)
      it = make_item(rqs_pkg::OP_ADD_CPU, int'($urandom_range(0, 7)), slot);
    else if (pick < 48) it = make_item(rqs_pkg::OP_REMOVE, 0, slot);
    else if (pick < 75)
      it = make_item(rqs_pkg::OP_SCHEDULE, int'($urandom_range(0, 7)), slot);
    else if (pick < 83) it = make_item(rqs_pkg::OP_MARK_STOPPED, 0, slot);
    else if (pick < 97) begin
      it = make_item(rqs_pkg::OP_POST_SIGNAL, 0, slot);
      if ($urandom_range(0, 3) != 0) it.signal_number = 6'($urandom_range(1, 32));
      if ($urandom_range(0, 5) == 0) it.signal_number = 6'd9;
    end else begin
      it = make_item(($urandom_range(0, 1) == 0) ? rqs_pkg::OP_RSVD_6 : rqs_pkg::OP_RSVD_7,
                     int'($urandom_range(0, 7)), slot);
    end
    if (it.op == rqs_pkg::OP_SCHEDULE && $urandom_range(0, 1) == 1)
      it.current_slot = 6'(slot);
    return it;
  endfunction

  // Driver: offers pending items, idling at random.
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && !in_stall) begin
        expected_results.push_back(predict_step(in_item));
        void'(pending_items.pop_front());
      end
      if (in_valid && in_stall) begin
        // Payload held while stalled.
      end else if (pending_items.size() > 0 && ($urandom_range(0, 99) >= idle_pct)) begin
        in_item <= pending_items[0];
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Long receiver hold-off, started once when its phase begins.
  always @(posedge clk) begin
    if (phase == HOLD_PHASE && !hold_armed) begin
      hold_armed <= 1'b1;
      hold_off <= HOLD_CYCLES;
    end else if (hold_off > 0) begin
      hold_off <= hold_off - 1;
    end
  end

  // Monitor: checks result items and drives the output stall.
  always @(posedge clk) begin
    rqs_pkg::out_item_t e;
    if (!rst) begin
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) report("result with nothing expected");
        else begin
          e = expected_results.pop_front();
          if (out_item.status !== e.status) report("status");
          if (out_item.chosen_cpu !== e.chosen_cpu) report("chosen_cpu");
          if (out_item.assigned_pid !== e.assigned_pid)
            report($sformatf("assigned_pid got %0d want %0d",
                             out_item.assigned_pid, e.assigned_pid));
          if (out_item.next_slot !== e.next_slot)
            report($sformatf("next_slot got %0d want %0d", out_item.next_slot, e.next_slot));
          if (out_item.next_is_idle !== e.next_is_idle) report("next_is_idle");
          if (out_item.deliver_signal !== e.deliver_signal)
            report($sformatf("deliver_signal got %0d want %0d",
                             out_item.deliver_signal, e.deliver_signal));
        end
      end
      if (hold_off > 0) begin
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(0, 99) < stall_pct);
      end
    end
  end

  // Watchdog on cycles without any accepted item or taken result.
  int quiet = 0;
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet >= IDLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  task automatic drain();
    while (pending_items.size() > 0 || in_valid || expected_results.size() > 0)
      @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic set_cpus(int n);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_data <= 4'(n);
    @(posedge clk);
    cfg_write <= 1'b0;
    cpus_cfg = 4'(n);
  endtask

  task automatic run_phase(int count, int ip, int sp);
    idle_pct = ip;
    stall_pct = sp;
    for (int i = 0; i < count; i++) pending_items.push_back(random_item());
    drain();
  endtask

  initial begin
    rqs_pkg::in_item_t it;
    clear_shadow();
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Directed: adds, extremes, stops, signals including kill, schedules, removes and reserved codes.
    set_cpus(8);
    pending_items.push_back(make_item(rqs_pkg::OP_SCHEDULE, 0, 0));
    it = make_item(rqs_pkg::OP_ADD_LEAST, 0, 0); it.kernel_thread = 1'b1;
    pending_items.push_back(it);
    it = make_item(rqs_pkg::OP_ADD_LEAST, 0, 63); it.kernel_thread = 1'b0;
    pending_items.push_back(it);
    pending_items.push_back(make_item(rqs_pkg::OP_ADD_CPU, 7, 5));
    pending_items.push_back(make_item(rqs_pkg::OP_ADD_CPU, 7, 5));
    pending_items.push_back(make_item(rqs_pkg::OP_ADD_CPU, 7, 6));
    it = make_item(rqs_pkg::OP_POST_SIGNAL, 0, 5); it.signal_number = 6'd32;
    pending_items.push_back(it);
    it = make_item(rqs_pkg::OP_POST_SIGNAL, 0, 5); it.signal_number = 6'd1;
    pending_items.push_back(it);
    it = make_item(rqs_pkg::OP_POST_SIGNAL, 0, 5); it.signal_number = 6'd0;
    pending_items.push_back(it);
    it = make_item(rqs_pkg::OP_POST_SIGNAL, 0, 5); it.signal_number = 6'd63;
    pending_items.push_back(it);
    it = make_item(rqs_pkg::OP_SCHEDULE, 7, 0); it.current_is_idle = 1'b1;
    pending_items.push_back(it);
    it = make_item(rqs_pkg::OP_SCHEDULE, 7, 0); it.current_slot = 6'd5;
    it.current_is_idle = 1'b0;
    pending_items.push_back(it);
    it = make_item(rqs_pkg::OP_POST_SIGNAL, 0, 6); it.signal_number = 6'd9;
    pending_items.push_back(it);
    it = make_item(rqs_pkg::OP_SCHEDULE, 7, 0); it.current_slot = 6'd5;
    it.current_is_idle = 1'b0;
    pending_items.push_back(it);
    it = make_item(rqs_pkg::OP_MARK_STOPPED, 0, 5); it.stopped_value = 1'b1;
    pending_items.push_back(it);
    it = make_item(rqs_pkg::OP_SCHEDULE, 7, 0); it.current_is_idle = 1'b1;
    pending_items.push_back(it);
    it = make_item(rqs_pkg::OP_MARK_STOPPED, 0, 5); it.stopped_value = 1'b0;
    pending_items.push_back(it);
    pending_items.push_back(make_item(rqs_pkg::OP_REMOVE, 0, 5));
    pending_items.push_back(make_item(rqs_pkg::OP_REMOVE, 0, 5));
    pending_items.push_back(make_item(rqs_pkg::OP_REMOVE, 0, 63));
    pending_items.push_back(make_item(rqs_pkg::OP_RSVD_6, 0, 1));
    pending_items.push_back(make_item(rqs_pkg::OP_RSVD_7, 0, 1));
    drain();

    // Random phases across settings and idling patterns.
    set_cpus(1);  run_phase(100, 0, 0);
    set_cpus(0);  run_phase(60, 67, 0);
    set_cpus(15); run_phase(100, 0, 67);
    set_cpus(3);  run_phase(80, 6, 6);
    // Long receiver hold-off while the sender keeps offering.
    phase = HOLD_PHASE;
    set_cpus(8);  run_phase(80, 0, 0);
    set_cpus(5);  run_phase(100, 20, 20);
    set_cpus(2);  run_phase(80, 0, 0);

    if (errors == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end
endmodule
